FILE: src/c8ie_pkg.sv
// Shared types, constants and codes for the CHIP-8 instruction execute core.
package c8ie_pkg;

  localparam int STACK_DEPTH   = 16;
  localparam int NUM_VREGS     = 16;
  localparam int ADDRESS_SPACE = 4096;

  localparam int PC_W   = $clog2(ADDRESS_SPACE);
  localparam int VIDX_W = $clog2(NUM_VREGS);
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int SA_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [VIDX_W-1:0] VIDX_V0 = VIDX_W'(0);
  localparam logic [VIDX_W-1:0] VIDX_VF = VIDX_W'(NUM_VREGS - 1);

  localparam logic [15:0] INS_CLS = 16'h00E0;
  localparam logic [15:0] INS_RET = 16'h00EE;

  typedef enum logic [3:0] {
    OP_SYS  = 4'h0,
    OP_JP   = 4'h1,
    OP_CALL = 4'h2,
    OP_SE   = 4'h3,
    OP_SNE  = 4'h4,
    OP_SER  = 4'h5,
    OP_LD   = 4'h6,
    OP_ADD  = 4'h7,
    OP_ALU  = 4'h8,
    OP_SNER = 4'h9,
    OP_LDI  = 4'hA,
    OP_JPV0 = 4'hB,
    OP_RND  = 4'hC
  } opcode_t;

  typedef enum logic [3:0] {
    ALU_MOV  = 4'h0,
    ALU_OR   = 4'h1,
    ALU_AND  = 4'h2,
    ALU_XOR  = 4'h3,
    ALU_ADD  = 4'h4,
    ALU_SUB  = 4'h5,
    ALU_SHR  = 4'h6,
    ALU_SUBN = 4'h7,
    ALU_SHL  = 4'hE
  } alu_fn_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNIMPL    = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic              en;
    logic [VIDX_W-1:0] x;
    logic [7:0]        dv;
    logic              fw;
    logic              fv;
  } vreg_wr_t;

  typedef struct packed {
    logic            en;
    logic [SA_W-1:0] addr;
    logic [PC_W-1:0] data;
  } stk_wr_t;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              dest_written;
    logic [VIDX_W-1:0] dest_index;
    logic [7:0]        dest_value;
    logic              flag_written;
    logic              flag_value;
    logic [PC_W-1:0]   index_value;
    logic              clear_screen;
    status_t           exec_status;
  } result_t;

endpackage

FILE: src/chip8_instruction_execute_top.sv
// CHIP-8 instruction execute core: top level with pipeline, PC, I and stack pointer.
//
// Input channel (in_valid / in_stall): one request carries an instruction
// word, fetched externally at the PC last reported, and a random byte.
// Output channel (out_valid / out_stall): one result per request with the
// next PC, Vx and VF writes, the I register, a clear-screen pulse and a
// status code.
// Pipeline: a request accepted is registered into the execute stage, and its
// result is registered into the output register when the execute stage
// advances. Throughput: one request per cycle while the output is not stalled; the
// register file and stack memories are read as the request is accepted and
// written back when it leaves the execute stage, with bypass of the last
// write covering back-to-back dependencies.
// Reset (rst, synchronous): V registers, I, PC and stack pointer clear to
// zero, both stages empty. Stack contents stay undefined until pushed.
// Output stall: the output register holds its result and the execute stage
// keeps one more request; in_stall rises once both are occupied.
module chip8_instruction_execute_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] instruction,
  input  logic [7:0]  random_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] next_pc,
  output logic        dest_written,
  output logic [3:0]  dest_index,
  output logic [7:0]  dest_value,
  output logic        flag_written,
  output logic        flag_value,
  output logic [11:0] index_value,
  output logic        clear_screen,
  output logic [1:0]  exec_status
);

  logic                             accept;
  logic                             e_valid;
  logic                             e_adv;
  logic                             commit;
  logic [15:0]                      e_ins;
  logic [7:0]                       e_rnd;
  logic [c8ie_pkg::PC_W-1:0]        pc;
  logic [c8ie_pkg::SP_W-1:0]        sp;
  logic [c8ie_pkg::PC_W-1:0]        ireg;
  logic [c8ie_pkg::SP_W-1:0]        sp_next;
  logic [c8ie_pkg::PC_W-1:0]        ireg_next;
  logic [c8ie_pkg::SP_W-1:0]        rd_sp;
  logic [7:0]                       vx;
  logic [7:0]                       vy;
  logic [7:0]                       v0;
  logic [c8ie_pkg::PC_W-1:0]        stack_top;
  c8ie_pkg::result_t                res;
  c8ie_pkg::result_t                out_res;
  c8ie_pkg::vreg_wr_t               ex_vwr;
  c8ie_pkg::vreg_wr_t               vwr;
  c8ie_pkg::stk_wr_t                ex_swr;
  c8ie_pkg::stk_wr_t                swr;

  assign e_adv    = !out_valid || !out_stall;
  assign commit   = e_valid && e_adv;
  assign in_stall = e_valid && !e_adv;
  assign accept   = in_valid && !in_stall;
  assign rd_sp    = commit ? sp_next : sp;

  always_comb begin
    vwr    = ex_vwr;
    vwr.en = ex_vwr.en && commit;
    swr    = ex_swr;
    swr.en = ex_swr.en && commit;
  end

  c8ie_vregs u_vregs (
    .clk   (clk),
    .rst   (rst),
    .rd_en (accept),
    .rd_x  (instruction[11:8]),
    .rd_y  (instruction[7:4]),
    .wr    (vwr),
    .vx    (vx),
    .vy    (vy),
    .v0    (v0)
  );

  c8ie_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .rd_en (accept),
    .rd_sp (rd_sp),
    .wr    (swr),
    .top   (stack_top)
  );

  c8ie_exec u_exec (
    .ins       (e_ins),
    .rnd       (e_rnd),
    .vx        (vx),
    .vy        (vy),
    .v0        (v0),
    .pc        (pc),
    .sp        (sp),
    .ireg      (ireg),
    .stack_top (stack_top),
    .res       (res),
    .vwr       (ex_vwr),
    .swr       (ex_swr),
    .sp_next   (sp_next),
    .ireg_next (ireg_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
      pc        <= '0;
      sp        <= '0;
      ireg      <= '0;
    end else begin
      if (accept) begin
        e_valid <= 1'b1;
      end else if (e_adv) begin
        e_valid <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
        pc        <= res.next_pc;
        sp        <= sp_next;
        ireg      <= ireg_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_ins <= instruction;
      e_rnd <= random_byte;
    end
    if (commit) begin
      out_res <= res;
    end
  end

  assign next_pc      = out_res.next_pc;
  assign dest_written = out_res.dest_written;
  assign dest_index   = out_res.dest_index;
  assign dest_value   = out_res.dest_value;
  assign flag_written = out_res.flag_written;
  assign flag_value   = out_res.flag_value;
  assign index_value  = out_res.index_value;
  assign clear_screen = out_res.clear_screen;
  assign exec_status  = out_res.exec_status;

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= c8ie_pkg::SP_W'(c8ie_pkg::STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_pc_tracks_out: assert property (@(posedge clk) disable iff (rst)
    commit |=> pc == next_pc && out_valid)
    else $error("PC differs from reported next PC");

  a_cls_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && clear_screen |-> !dest_written && !flag_written &&
      exec_status == c8ie_pkg::ST_OK)
    else $error("clear-screen result carries register writes");

  a_quiet_dest: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dest_written |-> dest_index == '0 && dest_value == '0 && !flag_written)
    else $error("destination fields set without a register write");

endmodule

FILE: src/c8ie_vregs.sv
// V register file: synchronous memory with valid bits, write bypass, V0 and VF registers.
module c8ie_vregs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [c8ie_pkg::VIDX_W-1:0]   rd_x,
  input  logic [c8ie_pkg::VIDX_W-1:0]   rd_y,
  input  c8ie_pkg::vreg_wr_t            wr,
  output logic [7:0]                    vx,
  output logic [7:0]                    vy,
  output logic [7:0]                    v0
);

  logic [7:0]                        mem [c8ie_pkg::NUM_VREGS];
  logic [c8ie_pkg::NUM_VREGS-1:0]    valid;
  logic [7:0]                        rdx;
  logic [7:0]                        rdy;
  logic [c8ie_pkg::VIDX_W-1:0]       rx;
  logic [c8ie_pkg::VIDX_W-1:0]       ry;
  logic                              lw_valid;
  logic [c8ie_pkg::VIDX_W-1:0]       lw_addr;
  logic [7:0]                        lw_data;
  logic [7:0]                        vf;
  logic [7:0]                        vreg0;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.x] <= wr.dv;
    end
    if (rd_en) begin
      rdx <= mem[rd_x];
      rdy <= mem[rd_y];
      rx  <= rd_x;
      ry  <= rd_y;
    end
    if (wr.en) begin
      lw_addr <= wr.x;
      lw_data <= wr.dv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      lw_valid <= 1'b0;
      vf       <= '0;
      vreg0    <= '0;
    end else begin
      if (wr.en) begin
        valid[wr.x] <= 1'b1;
        lw_valid    <= 1'b1;
        if (wr.x == c8ie_pkg::VIDX_V0) begin
          vreg0 <= wr.dv;
        end
      end
      if (wr.en && wr.fw) begin
        vf <= {7'd0, wr.fv};
      end else if (wr.en && wr.x == c8ie_pkg::VIDX_VF) begin
        vf <= wr.dv;
      end
    end
  end

  function automatic logic [7:0] pick(input logic [c8ie_pkg::VIDX_W-1:0] a,
                                      input logic [7:0] rd,
                                      input logic [7:0] r0,
                                      input logic [7:0] rf,
                                      input logic lv,
                                      input logic [c8ie_pkg::VIDX_W-1:0] la,
                                      input logic [7:0] ld,
                                      input logic [c8ie_pkg::NUM_VREGS-1:0] vb);
    logic [7:0] r;
    if (a == c8ie_pkg::VIDX_V0) begin
      r = r0;
    end else if (a == c8ie_pkg::VIDX_VF) begin
      r = rf;
    end else if (lv && la == a) begin
      r = ld;
    end else if (vb[a]) begin
      r = rd;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  assign vx = pick(rx, rdx, vreg0, vf, lw_valid, lw_addr, lw_data, valid);
  assign vy = pick(ry, rdy, vreg0, vf, lw_valid, lw_addr, lw_data, valid);
  assign v0 = vreg0;

endmodule

FILE: src/c8ie_stack.sv
// Call stack: synchronous memory with top-of-stack read and write bypass.
module c8ie_stack (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [c8ie_pkg::SP_W-1:0]    rd_sp,
  input  c8ie_pkg::stk_wr_t            wr,
  output logic [c8ie_pkg::PC_W-1:0]    top
);

  logic [c8ie_pkg::PC_W-1:0] mem [c8ie_pkg::STACK_DEPTH];
  logic [c8ie_pkg::SP_W-1:0] sp_dec;
  logic [c8ie_pkg::SA_W-1:0] ra_next;
  logic [c8ie_pkg::SA_W-1:0] ra;
  logic [c8ie_pkg::PC_W-1:0] rdata;
  logic                      lw_valid;
  logic [c8ie_pkg::SA_W-1:0] lw_addr;
  logic [c8ie_pkg::PC_W-1:0] lw_data;

  assign sp_dec  = rd_sp - c8ie_pkg::SP_W'(1);
  assign ra_next = sp_dec[c8ie_pkg::SA_W-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
      lw_addr      <= wr.addr;
      lw_data      <= wr.data;
    end
    if (rd_en) begin
      rdata <= mem[ra_next];
      ra    <= ra_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (wr.en) begin
      lw_valid <= 1'b1;
    end
  end

  assign top = (lw_valid && lw_addr == ra) ? lw_data : rdata;

endmodule

FILE: src/c8ie_exec.sv
// Instruction decode and execute: next PC, register writes, stack and I updates.
module c8ie_exec (
  input  logic [15:0]                   ins,
  input  logic [7:0]                    rnd,
  input  logic [7:0]                    vx,
  input  logic [7:0]                    vy,
  input  logic [7:0]                    v0,
  input  logic [c8ie_pkg::PC_W-1:0]     pc,
  input  logic [c8ie_pkg::SP_W-1:0]     sp,
  input  logic [c8ie_pkg::PC_W-1:0]     ireg,
  input  logic [c8ie_pkg::PC_W-1:0]     stack_top,
  output c8ie_pkg::result_t             res,
  output c8ie_pkg::vreg_wr_t            vwr,
  output c8ie_pkg::stk_wr_t             swr,
  output logic [c8ie_pkg::SP_W-1:0]     sp_next,
  output logic [c8ie_pkg::PC_W-1:0]     ireg_next
);

  logic [3:0]                    op;
  logic [c8ie_pkg::VIDX_W-1:0]   x;
  logic [3:0]                    n;
  logic [7:0]                    kk;
  logic [c8ie_pkg::PC_W-1:0]     nnn;
  logic [c8ie_pkg::PC_W-1:0]     pc_inc;
  logic [c8ie_pkg::PC_W-1:0]     pc_skip;
  logic [8:0]                    sum;
  logic [c8ie_pkg::PC_W-1:0]     npc;
  logic                          dw;
  logic [7:0]                    dv;
  logic                          fw;
  logic                          fv;
  logic                          cls;
  c8ie_pkg::status_t             st;

  assign op      = ins[15:12];
  assign x       = ins[11:8];
  assign n       = ins[3:0];
  assign kk      = ins[7:0];
  assign nnn     = ins[11:0];
  assign pc_inc  = pc + c8ie_pkg::PC_W'(2);
  assign pc_skip = pc + c8ie_pkg::PC_W'(4);
  assign sum     = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    npc       = pc_inc;
    sp_next   = sp;
    ireg_next = ireg;
    dw        = 1'b0;
    dv        = '0;
    fw        = 1'b0;
    fv        = 1'b0;
    cls       = 1'b0;
    st        = c8ie_pkg::ST_OK;
    swr.en    = 1'b0;
    swr.addr  = sp[c8ie_pkg::SA_W-1:0];
    swr.data  = pc_inc;
    unique case (op)
      c8ie_pkg::OP_SYS: begin
        if (ins == c8ie_pkg::INS_CLS) begin
          cls = 1'b1;
        end else if (ins == c8ie_pkg::INS_RET) begin
          if (sp == '0) begin
            st = c8ie_pkg::ST_UNDERFLOW;
          end else begin
            sp_next = sp - c8ie_pkg::SP_W'(1);
            npc     = stack_top;
          end
        end else begin
          st = c8ie_pkg::ST_UNIMPL;
        end
      end
      c8ie_pkg::OP_JP: npc = nnn;
      c8ie_pkg::OP_CALL: begin
        if (sp >= c8ie_pkg::SP_W'(c8ie_pkg::STACK_DEPTH)) begin
          st = c8ie_pkg::ST_OVERFLOW;
        end else begin
          swr.en  = 1'b1;
          sp_next = sp + c8ie_pkg::SP_W'(1);
          npc     = nnn;
        end
      end
      c8ie_pkg::OP_SE: begin
        if (vx == kk) npc = pc_skip;
      end
      c8ie_pkg::OP_SNE: begin
        if (vx != kk) npc = pc_skip;
      end
      c8ie_pkg::OP_SER: begin
        if (n != 4'd0) st = c8ie_pkg::ST_UNIMPL;
        else if (vx == vy) npc = pc_skip;
      end
      c8ie_pkg::OP_LD: begin
        dw = 1'b1;
        dv = kk;
      end
      c8ie_pkg::OP_ADD: begin
        dw = 1'b1;
        dv = vx + kk;
      end
      c8ie_pkg::OP_ALU: begin
        dw = 1'b1;
        unique case (n)
          c8ie_pkg::ALU_MOV: dv = vy;
          c8ie_pkg::ALU_OR:  dv = vx | vy;
          c8ie_pkg::ALU_AND: dv = vx & vy;
          c8ie_pkg::ALU_XOR: dv = vx ^ vy;
          c8ie_pkg::ALU_ADD: begin
            dv = sum[7:0];
            fw = 1'b1;
            fv = sum[8];
          end
          c8ie_pkg::ALU_SUB: begin
            dv = vx - vy;
            fw = 1'b1;
            fv = (vx >= vy);
          end
          c8ie_pkg::ALU_SHR: begin
            dv = {1'b0, vx[7:1]};
            fw = 1'b1;
            fv = vx[0];
          end
          c8ie_pkg::ALU_SUBN: begin
            dv = vy - vx;
            fw = 1'b1;
            fv = (vy >= vx);
          end
          c8ie_pkg::ALU_SHL: begin
            dv = {vx[6:0], 1'b0};
            fw = 1'b1;
            fv = vx[7];
          end
          default: begin
            dw = 1'b0;
            st = c8ie_pkg::ST_UNIMPL;
          end
        endcase
      end
      c8ie_pkg::OP_SNER: begin
        if (n != 4'd0) st = c8ie_pkg::ST_UNIMPL;
        else if (vx != vy) npc = pc_skip;
      end
      c8ie_pkg::OP_LDI:  ireg_next = nnn;
      c8ie_pkg::OP_JPV0: npc = nnn + {{(c8ie_pkg::PC_W-8){1'b0}}, v0};
      c8ie_pkg::OP_RND: begin
        dw = 1'b1;
        dv = rnd & kk;
      end
      default: st = c8ie_pkg::ST_UNIMPL;
    endcase
  end

  always_comb begin
    vwr.en = dw;
    vwr.x  = x;
    vwr.dv = dv;
    vwr.fw = fw;
    vwr.fv = fv;

    res.next_pc      = npc;
    res.dest_written = dw;
    res.dest_index   = dw ? x : '0;
    res.dest_value   = dw ? dv : '0;
    res.flag_written = fw;
    res.flag_value   = fw & fv;
    res.index_value  = ireg_next;
    res.clear_screen = cls;
    res.exec_status  = st;
  end

endmodule
